[rtl/core/tfm_pkg.sv]
// ----------------------------------------------------------------------------
// tfm_pkg: shared types and constants of the trapezoid fuzzifier
// Region codes, configuration register indexes, setup states, breakpoint
// bundle and reset values used by the core, its setup unit and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package tfm_pkg;

    // Default number of fraction bits of the membership degree
    localparam int FRAC_BITS_DEF = 15;

    // Width of a signed breakpoint: center plus/minus core and slope widths
    localparam int BP_W = 19;

    // Fixed slope divisor of the fixed width mode
    localparam logic [15:0] MODE0_DIV = 16'd15;

    // Reciprocal of the fixed divisor: spread / 15 == (spread * 34953) >> 19
    // for every 16-bit spread
    localparam logic [16:0] MODE0_RECIP = 17'd34953;
    localparam int          MODE0_SHIFT = 19;

    // Register reset values
    localparam logic signed [15:0] CENTER_RST = 16'sd0;
    localparam logic [15:0]        SPREAD_RST = 16'd0;
    localparam logic               MODE_RST   = 1'b0;
    localparam logic [15:0]        FACTOR_RST = 16'd15;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_CENTER = 2'd0,
        CFG_SPREAD = 2'd1,
        CFG_MODE   = 2'd2,
        CFG_FACTOR = 2'd3
    } cfg_index_t;

    // Region of the trapezoid a sample falls in
    typedef enum logic [1:0] {
        RGN_OUTSIDE = 2'd0,
        RGN_RISING  = 2'd1,
        RGN_CORE    = 2'd2,
        RGN_FALLING = 2'd3
    } region_t;

    // Breakpoint setup sequencer
    typedef enum logic [1:0] {
        SETUP_IDLE,
        SETUP_LOAD,
        SETUP_DIV,
        SETUP_BUILD
    } setup_state_t;

    // Breakpoints and slope divisor handed from setup to the datapath
    typedef struct packed {
        logic signed [BP_W-1:0] bp_a;
        logic signed [BP_W-1:0] bp_b;
        logic signed [BP_W-1:0] bp_c;
        logic signed [BP_W-1:0] bp_d;
        logic [15:0]            den;
        logic                   busy;
    } tfm_bounds_t;

    // Breakpoints of the reset configuration: zero widths, widened trapezoid
    localparam logic signed [BP_W-1:0] BP_A_RST = -19'sd2;
    localparam logic signed [BP_W-1:0] BP_B_RST = -19'sd1;
    localparam logic signed [BP_W-1:0] BP_C_RST = 19'sd1;
    localparam logic signed [BP_W-1:0] BP_D_RST = 19'sd2;
    localparam logic [15:0]            DEN_RST  = 16'd1;

endpackage

`default_nettype wire

[rtl/core/tfm_cfg.sv]
// ----------------------------------------------------------------------------
// tfm_cfg: configuration registers and breakpoint setup
// Holds the four registers. After each write a sequencer finds the slope
// width, by a reciprocal multiply for the fixed divisor or one quotient bit
// a cycle for the factor, then builds the breakpoints.
// ----------------------------------------------------------------------------
`default_nettype none

module tfm_cfg
    import tfm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output      tfm_bounds_t bounds
);

    logic signed [15:0] center_reg, center_next;
    logic [15:0]        spread_reg, spread_next;
    logic               mode_reg,   mode_next;
    logic [15:0]        factor_reg, factor_next;

    setup_state_t state_reg, state_next;
    logic [15:0]  dvs_reg, dvs_next;
    logic [15:0]  rem_reg, rem_next;
    logic [15:0]  quo_reg, quo_next;
    logic [3:0]   cnt_reg, cnt_next;

    logic signed [BP_W-1:0] bp_a_reg, bp_a_next;
    logic signed [BP_W-1:0] bp_b_reg, bp_b_next;
    logic signed [BP_W-1:0] bp_c_reg, bp_c_next;
    logic signed [BP_W-1:0] bp_d_reg, bp_d_next;
    logic [15:0]            den_reg,  den_next;

    logic                   cfg_wr;
    logic [15:0]            factor_eff;
    logic [16:0]            rem_shift;
    logic                   sub_ok;
    logic [34:0]            recip_prod;
    logic [15:0]            w_fixed;
    logic [15:0]            half_w;
    logic signed [BP_W-1:0] cen_ext;
    logic signed [BP_W-1:0] h_ext;
    logic signed [BP_W-1:0] w_ext;
    logic                   widen;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // Zero factor acts as one
    assign factor_eff = (factor_reg == 16'd0) ? 16'd1 : factor_reg;

    // One restoring division step
    assign rem_shift = {rem_reg, quo_reg[15]};
    assign sub_ok    = (rem_shift >= {1'b0, dvs_reg});

    // Fixed divisor slope width by reciprocal multiply
    assign recip_prod = {19'd0, spread_reg} * {18'd0, MODE0_RECIP};
    assign w_fixed    = recip_prod[MODE0_SHIFT +: 16];

    // Core half-width and widened case
    assign half_w  = mode_reg ? {1'b0, factor_eff[15:1]} : {1'b0, quo_reg[15:1]};
    assign cen_ext = BP_W'(center_reg);
    assign h_ext   = $signed({{(BP_W-16){1'b0}}, half_w});
    assign w_ext   = $signed({{(BP_W-16){1'b0}}, quo_reg});
    assign widen   = (quo_reg == 16'd0) && (half_w == 16'd0);

    // Register writes, setup sequencer and breakpoint build
    always_comb
    begin
        center_next = center_reg;
        spread_next = spread_reg;
        mode_next   = mode_reg;
        factor_next = factor_reg;
        state_next  = state_reg;
        dvs_next    = dvs_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        bp_a_next   = bp_a_reg;
        bp_b_next   = bp_b_reg;
        bp_c_next   = bp_c_reg;
        bp_d_next   = bp_d_reg;
        den_next    = den_reg;

        case (state_reg)
            SETUP_IDLE:
            begin
                state_next = SETUP_IDLE;
            end
            SETUP_LOAD:
            begin
                if (mode_reg)
                begin
                    dvs_next   = factor_eff;
                    rem_next   = 16'd0;
                    quo_next   = spread_reg;
                    cnt_next   = 4'd0;
                    state_next = SETUP_DIV;
                end
                else
                begin
                    // Fixed divisor needs no serial steps
                    quo_next   = w_fixed;
                    state_next = SETUP_BUILD;
                end
            end
            SETUP_DIV:
            begin
                rem_next = sub_ok ? 16'(rem_shift - {1'b0, dvs_reg}) : rem_shift[15:0];
                quo_next = {quo_reg[14:0], sub_ok};
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    state_next = SETUP_BUILD;
                end
            end
            SETUP_BUILD:
            begin
                if (widen)
                begin
                    bp_a_next = cen_ext - BP_W'(2);
                    bp_b_next = cen_ext - BP_W'(1);
                    bp_c_next = cen_ext + BP_W'(1);
                    bp_d_next = cen_ext + BP_W'(2);
                    den_next  = 16'd1;
                end
                else
                begin
                    bp_a_next = cen_ext - h_ext - w_ext;
                    bp_b_next = cen_ext - h_ext;
                    bp_c_next = cen_ext + h_ext;
                    bp_d_next = cen_ext + h_ext + w_ext;
                    den_next  = quo_reg;
                end
                state_next = SETUP_IDLE;
            end
            default:
            begin
                state_next = SETUP_IDLE;
            end
        endcase

        // A write updates its register and restarts the setup
        if (cfg_wr)
        begin
            case (cfg_index)
                CFG_CENTER: center_next = $signed(cfg_data);
                CFG_SPREAD: spread_next = cfg_data;
                CFG_MODE:   mode_next   = cfg_data[0];
                CFG_FACTOR: factor_next = cfg_data;
                default:    center_next = center_reg;
            endcase
            state_next = SETUP_LOAD;
        end
    end

    // Hold registers and sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg <= CENTER_RST;
            spread_reg <= SPREAD_RST;
            mode_reg   <= MODE_RST;
            factor_reg <= FACTOR_RST;
            state_reg  <= SETUP_IDLE;
            bp_a_reg   <= BP_A_RST;
            bp_b_reg   <= BP_B_RST;
            bp_c_reg   <= BP_C_RST;
            bp_d_reg   <= BP_D_RST;
            den_reg    <= DEN_RST;
            cnt_reg    <= 4'd0;
        end
        else
        begin
            center_reg <= center_next;
            spread_reg <= spread_next;
            mode_reg   <= mode_next;
            factor_reg <= factor_next;
            state_reg  <= state_next;
            bp_a_reg   <= bp_a_next;
            bp_b_reg   <= bp_b_next;
            bp_c_reg   <= bp_c_next;
            bp_d_reg   <= bp_d_next;
            den_reg    <= den_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Divider working registers
    always_ff @(posedge clk)
    begin
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign bounds.bp_a = bp_a_reg;
    assign bounds.bp_b = bp_b_reg;
    assign bounds.bp_c = bp_c_reg;
    assign bounds.bp_d = bp_d_reg;
    assign bounds.den  = den_reg;
    assign bounds.busy = (state_reg != SETUP_IDLE);

endmodule

`default_nettype wire

[rtl/core/tfm_div_pipe.sv]
// ----------------------------------------------------------------------------
// tfm_div_pipe: pipelined slope divider
// Divides remainder * 2^FRAC_BITS by the slope width, one quotient bit per
// stage, with the item's valid bit and region travelling alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module tfm_div_pipe
    import tfm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 adv,
    input  wire logic [15:0]          den,
    input  wire logic                 in_vld,
    input  wire region_t              in_rgn,
    input  wire logic [15:0]          in_rem,
    output      logic                 out_vld,
    output      region_t              out_rgn,
    output      logic [FRAC_BITS-1:0] out_quo
);

    logic                 vld_reg [FRAC_BITS];
    region_t              rgn_reg [FRAC_BITS];
    logic [15:0]          rem_reg [FRAC_BITS];
    logic [FRAC_BITS-1:0] quo_reg [FRAC_BITS];

    for (genvar k = 0; k < FRAC_BITS; k++)
    begin : g_stage
        logic                 src_vld;
        region_t              src_rgn;
        logic [15:0]          src_rem;
        logic [FRAC_BITS-1:0] src_quo;
        logic [16:0]          rem_shift;
        logic                 sub_ok;
        logic [15:0]          rem_next;
        logic [FRAC_BITS-1:0] quo_next;

        // Take the previous stage, or the pipe input at the first stage
        if (k == 0)
        begin : g_first
            assign src_vld = in_vld;
            assign src_rgn = in_rgn;
            assign src_rem = in_rem;
            assign src_quo = '0;
        end
        else
        begin : g_next
            assign src_vld = vld_reg[k-1];
            assign src_rgn = rgn_reg[k-1];
            assign src_rem = rem_reg[k-1];
            assign src_quo = quo_reg[k-1];
        end

        // One restoring step: shift, compare, subtract
        assign rem_shift = {src_rem, 1'b0};
        assign sub_ok    = (rem_shift >= {1'b0, den});
        assign rem_next  = sub_ok ? 16'(rem_shift - {1'b0, den}) : rem_shift[15:0];
        assign quo_next  = {src_quo[FRAC_BITS-2:0], sub_ok};

        // Advance the valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[k] <= src_vld;
            end
        end

        // Advance the payload
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rgn_reg[k] <= src_rgn;
                rem_reg[k] <= rem_next;
                quo_reg[k] <= quo_next;
            end
        end
    end

    assign out_vld = vld_reg[FRAC_BITS-1];
    assign out_rgn = rgn_reg[FRAC_BITS-1];
    assign out_quo = quo_reg[FRAC_BITS-1];

endmodule

`default_nettype wire

[rtl/core/trapezoid_fuzzy_membership.sv]
// ----------------------------------------------------------------------------
// trapezoid_fuzzy_membership: trapezoidal fuzzifier
// Maps each signed sample to a membership degree in unsigned Q1.FRAC_BITS
// and to the trapezoid region it falls in.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   center (0), spread (1), width_mode (2) and divisor_factor (3). It is always
//   ready. Each write starts a breakpoint setup: with width_mode 1 the serial
//   spread divider gives the slope width, with width_mode 0 a reciprocal
//   multiply gives it; in_ready stays low during setup.
//   Sample channel (in_valid/in_ready, sample_value) takes one item per cycle
//   outside setup while the result channel is not stalled. Result channel
//   (out_valid/out_ready, membership, region) gives one result item per
//   sample, in order. The pipeline has one compare stage, FRAC_BITS slope
//   divider stages of one quotient bit each and one output stage.
//   Throughput is one item per cycle when neither setup nor a stall holds it.
//   When the receiver stalls with a result waiting, every stage holds and
//   in_ready drops in the same cycle; nothing is lost or repeated.
//   Reset empties the pipeline and loads the register reset values, whose
//   breakpoints are ready at once.
// ----------------------------------------------------------------------------
`default_nettype none

module trapezoid_fuzzy_membership
    import tfm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output      logic        in_ready,
    input  wire logic signed [15:0] sample_value,
    output      logic        out_valid,
    input  wire logic        out_ready,
    output      logic [15:0] membership,
    output      logic [1:0]  region
);

    localparam logic [15:0] ONE_Q = 16'(1 << FRAC_BITS);

    tfm_bounds_t bounds;

    logic adv;
    logic accept;

    logic signed [BP_W-1:0] x_ext;
    logic signed [BP_W-1:0] da_next, dd_next;

    logic                   s1_vld_reg;
    logic                   lt_a_reg, gt_d_reg, lt_b_reg, gt_c_reg;
    logic signed [BP_W-1:0] da_reg, dd_reg;

    region_t                s1_rgn;
    logic [15:0]            s1_rem;

    logic                   div_vld;
    region_t                div_rgn;
    logic [FRAC_BITS-1:0]   div_quo;

    logic                   out_vld_reg;
    logic [15:0]            memb_reg, memb_next;
    region_t                rgn_reg;

    // Breakpoint registers and setup
    tfm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .bounds    (bounds)
    );

    // Whole pipe moves unless a result is stuck at the output
    assign adv      = !out_vld_reg || out_ready;
    assign in_ready = adv && !bounds.busy;
    assign accept   = in_valid && in_ready;

    // Stage 1: compare against breakpoints, take distances to the feet
    assign x_ext   = BP_W'(sample_value);
    assign da_next = x_ext - bounds.bp_a;
    assign dd_next = bounds.bp_d - x_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lt_a_reg <= (x_ext < bounds.bp_a);
            gt_d_reg <= (x_ext > bounds.bp_d);
            lt_b_reg <= (x_ext < bounds.bp_b);
            gt_c_reg <= (x_ext > bounds.bp_c);
            da_reg   <= da_next;
            dd_reg   <= dd_next;
        end
    end

    // Classify and pick the slope remainder for the divider
    always_comb
    begin
        s1_rgn = RGN_FALLING;
        s1_rem = dd_reg[15:0];
        if (lt_a_reg || gt_d_reg)
        begin
            s1_rgn = RGN_OUTSIDE;
            s1_rem = 16'd0;
        end
        else if (!lt_b_reg && !gt_c_reg)
        begin
            s1_rgn = RGN_CORE;
            s1_rem = 16'd0;
        end
        else if (lt_b_reg)
        begin
            s1_rgn = RGN_RISING;
            s1_rem = da_reg[15:0];
        end
    end

    // Slope divider stages
    tfm_div_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .den     (bounds.den),
        .in_vld  (s1_vld_reg),
        .in_rgn  (s1_rgn),
        .in_rem  (s1_rem),
        .out_vld (div_vld),
        .out_rgn (div_rgn),
        .out_quo (div_quo)
    );

    // Output stage: select degree by region
    always_comb
    begin
        case (div_rgn)
            RGN_OUTSIDE: memb_next = 16'd0;
            RGN_CORE:    memb_next = ONE_Q;
            RGN_RISING:  memb_next = 16'(div_quo);
            RGN_FALLING: memb_next = 16'(div_quo);
            default:     memb_next = 16'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= div_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            memb_reg <= memb_next;
            rgn_reg  <= div_rgn;
        end
    end

    assign out_valid  = out_vld_reg;
    assign membership = memb_reg;
    assign region     = rgn_reg;

endmodule

`default_nettype wire

[rtl/core/tfm_checker.sv]
// ----------------------------------------------------------------------------
// tfm_checker: port-level checks of the trapezoid fuzzifier
// Watches the top level's channels; bound to every instance of it.
// ----------------------------------------------------------------------------
`default_nettype none

module tfm_checker
    import tfm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] membership,
    input wire logic [1:0]  region
);

    localparam logic [15:0] ONE_Q = 16'(1 << FRAC_BITS);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(membership) && $stable(region))
        else $error("result changed while stalled");

    // Outside the trapezoid the degree is zero
    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (region == RGN_OUTSIDE) |-> (membership == 16'd0))
        else $error("nonzero degree outside the trapezoid");

    // In the core the degree is full
    a_core_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (region == RGN_CORE) |-> (membership == ONE_Q))
        else $error("core degree is not one");

    // A register write blocks samples while breakpoints rebuild
    a_setup_block: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !in_ready)
        else $error("sample taken during breakpoint setup");

endmodule

bind trapezoid_fuzzy_membership tfm_checker #(
    .FRAC_BITS (FRAC_BITS)
) u_tfm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .membership (membership),
    .region     (region)
);

`default_nettype wire

[tb/tfm_grade_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tfm_grade_checker: result checker of the trapezoid fuzzifier
// Tracks register writes, predicts the membership degree and region of every
// accepted sample, and compares each delivered result with the oldest
// prediction in order. Reports mismatches and counts them for the testbench.
// ----------------------------------------------------------------------------

module tfm_grade_checker
    import tfm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [15:0] sample_value,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [15:0]        membership,
    input  logic [1:0]         region,
    output int                 fail_count,
    output int                 grades_pending
);

    // One predicted result item
    typedef struct {
        logic [15:0] memb;
        region_t     rgn;
    } grade_t;

    grade_t grade_queue[$];

    // Shadow copy of the configuration registers
    logic signed [15:0] center_q;
    logic [15:0]        spread_q;
    logic               mode_q;
    logic [15:0]        factor_q;

    // Compute membership degree and region of one sample
    function automatic grade_t fuzzify(input logic signed [15:0] x);
        grade_t      g;
        int unsigned w;
        int unsigned h;
        int unsigned f;
        longint      xs;
        longint      cs;
        longint      ww;
        longint      hw;
        longint      a;
        longint      b;
        longint      c;
        longint      d;
        xs = x;
        cs = center_q;
        if (!mode_q)
        begin
            w = spread_q / MODE0_DIV;
            h = w / 2;
        end
        else
        begin
            // a zero factor acts as one
            f = (factor_q == '0) ? 1 : factor_q;
            w = spread_q / f;
            h = f / 2;
        end
        ww = w;
        hw = h;
        // widen a degenerate trapezoid so it keeps two slopes
        if (ww == 0 && hw == 0)
        begin
            a = cs - 2;
            b = cs - 1;
            c = cs + 1;
            d = cs + 2;
        end
        else
        begin
            b = cs - hw;
            c = cs + hw;
            a = b - ww;
            d = c + ww;
        end
        if (xs < a || xs > d)
        begin
            g.memb = '0;
            g.rgn  = RGN_OUTSIDE;
        end
        else if (xs >= b && xs <= c)
        begin
            g.memb = 16'(longint'(1) << FRAC_BITS_DEF);
            g.rgn  = RGN_CORE;
        end
        else if (xs < b)
        begin
            g.memb = 16'(((xs - a) << FRAC_BITS_DEF) / (b - a));
            g.rgn  = RGN_RISING;
        end
        else
        begin
            g.memb = 16'(((d - xs) << FRAC_BITS_DEF) / (d - c));
            g.rgn  = RGN_FALLING;
        end
        return g;
    endfunction

    // Watch all three channels at every edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        grade_t want;
        int     errs;
        if (!rst_n)
        begin
            grade_queue.delete();
            center_q       <= CENTER_RST;
            spread_q       <= SPREAD_RST;
            mode_q         <= MODE_RST;
            factor_q       <= FACTOR_RST;
            fail_count     <= 0;
            grades_pending <= 0;
        end
        else
        begin
            errs = 0;
            // track register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_CENTER: center_q <= cfg_data;
                    CFG_SPREAD: spread_q <= cfg_data;
                    CFG_MODE:   mode_q   <= cfg_data[0];
                    CFG_FACTOR: factor_q <= cfg_data;
                    default:    ;
                endcase
            end
            // predict each accepted sample
            if (in_valid && in_ready)
                grade_queue.push_back(fuzzify(sample_value));
            // compare each delivered result with the oldest prediction
            if (out_valid && out_ready)
            begin
                if (grade_queue.size() == 0)
                begin
                    $display("%0t: result with no sample waiting: membership %0d region %0d",
                             $time, membership, region);
                    errs++;
                end
                else
                begin
                    want = grade_queue.pop_front();
                    if (membership !== want.memb)
                    begin
                        $display("%0t: membership mismatch: expected %0d actual %0d",
                                 $time, want.memb, membership);
                        errs++;
                    end
                    if (region !== want.rgn)
                    begin
                        $display("%0t: region mismatch: expected %0d actual %0d",
                                 $time, want.rgn, region);
                        errs++;
                    end
                end
            end
            fail_count     <= fail_count + errs;
            grades_pending <= grade_queue.size();
        end
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the trapezoid fuzzifier
// Drives register settings and sample items through the valid/ready channels,
// first a directed set around breakpoints and register extremes, then random
// settings with samples aimed at the trapezoid, under several idling patterns.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------

module tb;
    import tfm_pkg::*;

    localparam int     RANDOM_ITEMS = 1200;
    localparam int     SETTLE_CYCLES = FRAC_BITS_DEF + 8;
    localparam longint TIMEOUT_NS = 2_000_000;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic signed [15:0] sample_value;
    logic               out_valid;
    logic               out_ready;
    logic [15:0]        membership;
    logic [1:0]         region;

    int fail_count;
    int grades_pending;
    int gap_pct;
    int stall_pct;

    // Rough trapezoid geometry of the current setting, used to aim samples
    longint aim_center;
    longint aim_core;
    longint aim_slope;

    trapezoid_fuzzy_membership DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample_value (sample_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .membership   (membership),
        .region       (region)
    );

    tfm_grade_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample_value   (sample_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .membership     (membership),
        .region         (region),
        .fail_count     (fail_count),
        .grades_pending (grades_pending)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Stall the result channel at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Write one register; leave cfg_valid high for a following write
    task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
    endtask

    // Write all registers and note the geometry for sample aiming
    task automatic configure(input logic signed [15:0] center, input logic [15:0] spread,
                             input logic mode, input logic [15:0] factor);
        int unsigned f;
        write_reg(CFG_CENTER, center);
        write_reg(CFG_SPREAD, spread);
        write_reg(CFG_MODE, {15'd0, mode});
        write_reg(CFG_FACTOR, factor);
        cfg_valid <= 1'b0;
        aim_center = center;
        if (!mode)
        begin
            aim_slope = spread / MODE0_DIV;
            aim_core  = aim_slope / 2;
        end
        else
        begin
            f = (factor == '0) ? 1 : factor;
            aim_slope = spread / f;
            aim_core  = f / 2;
        end
    endtask

    // Offer one sample, hold it until accepted, then maybe idle
    task automatic send_sample(input logic signed [15:0] x);
        in_valid     <= 1'b1;
        sample_value <= x;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        if ($urandom_range(99) < gap_pct)
        begin
            in_valid     <= 1'b0;
            sample_value <= 16'($urandom());
            do @(posedge clk); while ($urandom_range(99) < gap_pct);
        end
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (grades_pending != 0);
        @(posedge clk);
    endtask

    // Pick a random setting, favoring extremes and narrow trapezoids
    task automatic random_config();
        logic signed [15:0] center;
        logic [15:0]        spread;
        logic [15:0]        factor;
        case ($urandom_range(3))
            0:       center = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            1:       center = 16'($urandom_range(400)) - 16'd200;
            default: center = 16'($urandom());
        endcase
        case ($urandom_range(3))
            0:       spread = '0;
            1:       spread = '1;
            2:       spread = 16'($urandom_range(400));
            default: spread = 16'($urandom());
        endcase
        case ($urandom_range(4))
            0:       factor = '0;
            1:       factor = 16'd1;
            2:       factor = '1;
            3:       factor = 16'($urandom_range(2, 64));
            default: factor = 16'($urandom());
        endcase
        configure(center, spread, 1'($urandom_range(1)), factor);
    endtask

    // Draw a sample: mostly near the trapezoid, some on breakpoints, some anywhere
    function automatic logic signed [15:0] pick_sample();
        longint span;
        longint v;
        longint off;
        span = aim_core + aim_slope + 4;
        case ($urandom_range(9))
            0, 1:
                return 16'($urandom());
            2, 3:
            begin
                case ($urandom_range(4))
                    0:       off = aim_core;
                    1:       off = aim_core + 1;
                    2:       off = aim_core + aim_slope;
                    3:       off = aim_core + aim_slope + 1;
                    default: off = $urandom_range(3);
                endcase
                v = $urandom_range(1) ? aim_center + off : aim_center - off;
            end
            default:
                v = aim_center + longint'($urandom_range(32'(2 * span))) - span;
        endcase
        // clamp to the sample range
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return 16'(v);
    endfunction

    // Stimulus and verdict
    initial
    begin
        int phase;
        int sent;
        int n;
        rst_n        <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= CFG_CENTER;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        sample_value <= '0;
        gap_pct    = 0;
        stall_pct  = 0;
        aim_center = 0;
        aim_core   = 0;
        aim_slope  = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: widened trapezoid -2..2, plus sample extremes
        send_sample(-16'sd32768); send_sample(16'sd32767); send_sample(-16'sd3);
        send_sample(-16'sd2);     send_sample(-16'sd1);    send_sample(16'sd0);
        send_sample(16'sd1);      send_sample(16'sd2);     send_sample(16'sd3);

        // top center, widest spread, fixed divisor: rising slope below the top
        hold_until_drained();
        configure(16'sh7FFF, 16'hFFFF, 1'b0, 16'hFFFF);
        send_sample(16'sd26213); send_sample(16'sd26214); send_sample(16'sd28000);
        send_sample(16'sd30583); send_sample(16'sd32767);

        // bottom center, zero factor acts as one: falling slope spans everything
        hold_until_drained();
        configure(16'sh8000, 16'hFFFF, 1'b1, 16'h0000);
        send_sample(-16'sd32768); send_sample(-16'sd32767);
        send_sample(16'sd0);      send_sample(16'sd32767);

        // largest factor: zero slope width, core only
        hold_until_drained();
        configure(16'sd100, 16'd1000, 1'b1, 16'hFFFF);
        send_sample(-16'sd32768); send_sample(-16'sd32667);

        // narrow trapezoid -4..4 with truncated slope quotients
        hold_until_drained();
        configure(16'sd0, 16'd7, 1'b1, 16'd2);
        send_sample(-16'sd3); send_sample(16'sd3); send_sample(16'sd4);

        // factor one with no spread: degenerate, widens again
        hold_until_drained();
        configure(16'sd0, 16'd0, 1'b1, 16'd1);
        send_sample(-16'sd2); send_sample(-16'sd1);

        // random settings, rotating through idling patterns
        phase = 0;
        sent  = 0;
        while (sent < RANDOM_ITEMS)
        begin
            hold_until_drained();
            random_config();
            case (phase % 4)
                0:
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    gap_pct   = 57;
                    stall_pct = 0;
                end
                2:
                begin
                    gap_pct   = 0;
                    stall_pct = 57;
                end
                default:
                begin
                    gap_pct   = 23;
                    stall_pct = 23;
                end
            endcase
            n = $urandom_range(60, 140);
            for (int i = 0; i < n; i++)
            begin
                // pause mid-phase until the pipeline has emptied
                if (i == n / 2 && phase % 3 == 1)
                    hold_until_drained();
                send_sample(pick_sample());
            end
            sent += n;
            phase++;
        end

        // let the pipeline empty, then watch for stray results
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0 && grades_pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Guard against a hung handshake
    initial
    begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
